/* hw/rtl/whole_word_match_locator_macros.svh */
// Assertion helpers shared by the whole-word locator RTL.
`ifndef WHOLE_WORD_MATCH_LOCATOR_MACROS_SVH
`define WHOLE_WORD_MATCH_LOCATOR_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define WWML_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("wwml: invariant violated");

// Same-cycle implication.
`define WWML_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wwml: implication violated");

// Next-cycle implication.
`define WWML_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wwml: next-cycle check violated");

`endif

/* hw/rtl/wwml_pkg.sv */
`default_nettype none

package wwml_pkg;

    // Pattern register file holds 16 bytes whatever the configured maximum
    localparam int PatternBytes = 16;
    localparam int CountW       = 32;
    localparam int ColumnOutW   = 16;
    localparam int QueueDepth   = 4;

    // ASCII letter ranges
    localparam logic [7:0] UpperFirst = 8'd65;
    localparam logic [7:0] UpperLast  = 8'd90;
    localparam logic [7:0] LowerFirst = 8'd97;
    localparam logic [7:0] LowerLast  = 8'd122;

    typedef logic [7:0] byte_t;
    typedef byte_t [PatternBytes-1:0] pattern_t;

    typedef enum logic [1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REPORT_MATCH = 1'b0,
        REPORT_TOTAL = 1'b1
    } report_kind_t;

    typedef struct packed {
        report_kind_t            kind;
        logic [CountW-1:0]       line_number;
        logic [ColumnOutW-1:0]   column;
        logic [CountW-1:0]       count;
        logic                    last;
    } result_t;

    // Up to two reports written into the output queue per request
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic fits;    // byte agrees with its pattern byte, or lies beyond the pattern
        logic letter;  // byte is an ASCII letter
    } cell_flags_t;

    function automatic logic is_letter(input byte_t b);
        return ((b >= UpperFirst) && (b <= UpperLast)) ||
               ((b >= LowerFirst) && (b <= LowerLast));
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wwml_cell.sv */
`default_nettype none

// One window position: holds a text byte, passes it on, compares it.
module wwml_cell #(
    parameter int MAX_PATTERN = 16,
    parameter int IDX         = 0
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wwml_pkg::cell_ctrl_t      ctrl,
    input  wwml_pkg::byte_t           byte_in,
    input  wwml_pkg::pattern_t        pattern,
    input  wire [$clog2(MAX_PATTERN+1)-1:0] len,
    output wwml_pkg::byte_t           byte_out,
    output wwml_pkg::cell_flags_t     flags
);

    wwml_pkg::byte_t byte_reg, byte_next;
    logic [5:0]      len_w;
    logic [5:0]      pos;

    // Shift or clear the held byte
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = '0;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    // Newest byte faces the last pattern byte
    assign len_w = 6'(len);
    assign pos   = len_w - 6'd1 - 6'(IDX);

    always_comb begin
        flags.letter = wwml_pkg::is_letter(byte_reg);
        if (6'(IDX) < len_w) begin
            flags.fits = (byte_reg == pattern[pos[3:0]]);
        end else begin
            flags.fits = 1'b1;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

/* hw/rtl/wwml_out_queue.sv */
`default_nettype none

`include "whole_word_match_locator_macros.svh"

// Small report queue: takes up to two reports per cycle, hands out one.
module wwml_out_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wwml_pkg::push_t      push,
    input  wire                  m_ready,
    output logic                 m_valid,
    output wwml_pkg::result_t    head,
    output logic                 room
);

    localparam int PtrW = $clog2(wwml_pkg::QueueDepth);
    localparam int CntW = $clog2(wwml_pkg::QueueDepth + 1);

    wwml_pkg::result_t mem [wwml_pkg::QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              pop;
    logic [PtrW-1:0]   wr_ptr_second;

    assign m_valid       = (count_reg != '0);
    assign pop           = m_valid && m_ready;
    assign head          = mem[rd_ptr_reg];
    assign room          = (count_reg <= CntW'(wwml_pkg::QueueDepth - 2));
    assign wr_ptr_second = wr_ptr_reg + PtrW'(1);

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.num);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CntW'(push.num) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_second] <= push.second;
        end
    end

    `WWML_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CntW'(wwml_pkg::QueueDepth))
    `WWML_ASSERT_IMPL(a_push_has_room, aclk, aresetn, push.num != 2'd0, room)
    `WWML_ASSERT_NEXT(a_count_tracks, aclk, aresetn, aresetn, count_reg == CntW'($past(count_reg) + CntW'($past(push.num)) - CntW'($past(pop))))

endmodule

`default_nettype wire

/* hw/rtl/whole_word_match_locator.sv */
// Whole-word pattern locator. Text enters one byte per request on s_*, with
// s_line_end / s_text_end marking line and text ends. A row of MAX_PATTERN+1
// byte cells holds the tail of the current line; each cell compares its byte
// with its pattern byte, so a whole-word hit is known in the cycle a boundary
// (non-letter byte or marker) arrives. Throughput is one request per clock
// while s_ready is high; reports enter a four-entry queue, and s_ready drops
// while fewer than two entries are free, so a stalled m_ready, or a text end
// that closes on a hit (two reports), costs input cycles. The user must
// write pattern registers through cfg_* (index 0 low bytes, 1 high bytes,
// 2 length) only while the block is idle; the block does not enforce this.
`default_nettype none

`include "whole_word_match_locator_macros.svh"

module whole_word_match_locator #(
    parameter int MAX_PATTERN = 16,
    parameter int COLUMN_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [1:0]   cfg_index,
    input  wire [63:0]  cfg_data,
    // text in
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [7:0]   s_text_byte,
    input  wire         s_line_end,
    input  wire         s_text_end,
    // reports out
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_report_kind,
    output logic [31:0] m_line_number,
    output logic [15:0] m_column,
    output logic [31:0] m_occurrence_count,
    output logic        m_last_of_run
);

    localparam int LenW  = $clog2(MAX_PATTERN + 1);
    localparam int Cells = MAX_PATTERN + 1;
    localparam int ColW  = (COLUMN_BITS > wwml_pkg::ColumnOutW) ?
                           COLUMN_BITS : wwml_pkg::ColumnOutW;
    localparam logic [COLUMN_BITS-1:0] ColumnMax = '1;

    // Configuration registers
    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [4:0]  pat_len_reg;
    logic        alive_reg;

    // Line and count state
    logic [COLUMN_BITS-1:0]        bytes_reg, bytes_next;
    logic [wwml_pkg::CountW-1:0]   line_reg, line_next;
    logic [wwml_pkg::CountW-1:0]   match_reg, match_next;

    wwml_pkg::pattern_t    pattern;
    logic [4:0]            len_sat;
    logic [LenW-1:0]       len;
    logic [COLUMN_BITS-1:0] len_ext;
    wwml_pkg::cell_ctrl_t  cell_ctrl;
    wwml_pkg::byte_t       window [MAX_PATTERN];
    wwml_pkg::cell_flags_t flags [Cells];
    logic [Cells-1:0]      fits;
    logic [Cells-1:0]      letters;
    logic                  accept;
    logic                  marker;
    logic                  hit_base;
    logic                  hit;
    logic [COLUMN_BITS-1:0] col_full;
    logic [ColW-1:0]       col_wide;
    logic [wwml_pkg::ColumnOutW-1:0] col_out;
    logic [wwml_pkg::CountW-1:0]     count_inc;
    wwml_pkg::result_t     match_rep;
    wwml_pkg::result_t     total_rep;
    wwml_pkg::push_t       push;
    wwml_pkg::result_t     head;
    logic                  room;

    // Ready only once out of reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= 1'b0;
        end else begin
            alive_reg <= 1'b1;
        end
    end

    assign cfg_ready = alive_reg;
    assign s_ready   = alive_reg && room;
    assign accept    = s_valid && s_ready;
    assign marker    = s_line_end || s_text_end;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (wwml_pkg::cfg_index_t'(cfg_index))
                wwml_pkg::CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                wwml_pkg::CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                wwml_pkg::CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign pattern = wwml_pkg::pattern_t'({pat_high_reg, pat_low_reg});

    // Effective pattern length
    always_comb begin
        if (pat_len_reg == 5'd0) begin
            len_sat = 5'd1;
        end else if (pat_len_reg > 5'(MAX_PATTERN)) begin
            len_sat = 5'(MAX_PATTERN);
        end else begin
            len_sat = pat_len_reg;
        end
    end

    assign len     = LenW'(len_sat);
    assign len_ext = COLUMN_BITS'(len);

    assign cell_ctrl.shift = accept && !marker;
    assign cell_ctrl.clear = accept && marker;

    // Byte window: cell 0 holds the newest byte
    for (genvar k = 0; k < Cells; k++) begin : g_cell
        if (k < MAX_PATTERN) begin : g_mid
            wwml_cell #(.MAX_PATTERN(MAX_PATTERN), .IDX(k)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  ((k == 0) ? s_text_byte : window[(k == 0) ? 0 : k - 1]),
                .pattern  (pattern),
                .len      (len),
                .byte_out (window[k]),
                .flags    (flags[k])
            );
        end else begin : g_tail
            wwml_cell #(.MAX_PATTERN(MAX_PATTERN), .IDX(k)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (window[k - 1]),
                .pattern  (pattern),
                .len      (len),
                .byte_out (),
                .flags    (flags[k])
            );
        end
        assign fits[k]    = flags[k].fits;
        assign letters[k] = flags[k].letter;
    end

    // Whole-word hit ending at the newest byte
    assign hit_base = (bytes_reg >= len_ext) && (&fits) &&
                      ((bytes_reg == len_ext) || !letters[len]);
    assign hit      = accept && hit_base &&
                      (marker || !wwml_pkg::is_letter(s_text_byte));

    // Start column, capped to the report width
    assign col_full = (bytes_reg == ColumnMax) ? ColumnMax : bytes_reg - len_ext;
    assign col_wide = ColW'(col_full);
    assign col_out  = (col_wide > ColW'({wwml_pkg::ColumnOutW{1'b1}})) ?
                      {wwml_pkg::ColumnOutW{1'b1}} : col_wide[wwml_pkg::ColumnOutW-1:0];

    assign count_inc = (match_reg == '1) ? match_reg : match_reg + 1'b1;

    // Report payloads
    always_comb begin
        match_rep.kind        = wwml_pkg::REPORT_MATCH;
        match_rep.line_number = line_reg;
        match_rep.column      = col_out;
        match_rep.count       = count_inc;
        match_rep.last        = !s_text_end;

        total_rep.kind        = wwml_pkg::REPORT_TOTAL;
        total_rep.line_number = line_reg;
        total_rep.column      = '0;
        total_rep.count       = hit ? count_inc : match_reg;
        total_rep.last        = 1'b1;
    end

    always_comb begin
        push.first  = match_rep;
        push.second = total_rep;
        push.num    = 2'd0;
        if (accept) begin
            if (hit) begin
                push.num = s_text_end ? 2'd2 : 2'd1;
            end else if (s_text_end) begin
                push.first = total_rep;
                push.num   = 2'd1;
            end
        end
    end

    // Counter updates
    always_comb begin
        bytes_next = bytes_reg;
        line_next  = line_reg;
        match_next = hit ? count_inc : match_reg;
        if (accept) begin
            if (marker) begin
                bytes_next = '0;
                if (s_text_end) begin
                    line_next  = 32'd1;
                    match_next = '0;
                end else if (line_reg != '1) begin
                    line_next = line_reg + 1'b1;
                end
            end else if (bytes_reg != ColumnMax) begin
                bytes_next = bytes_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= '0;
            line_reg  <= 32'd1;
            match_reg <= '0;
        end else begin
            bytes_reg <= bytes_next;
            line_reg  <= line_next;
            match_reg <= match_next;
        end
    end

    wwml_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .head    (head),
        .room    (room)
    );

    assign m_report_kind      = head.kind;
    assign m_line_number      = head.line_number;
    assign m_column           = head.column;
    assign m_occurrence_count = head.count;
    assign m_last_of_run      = head.last;

    `WWML_ASSERT_IMPL(a_two_needs_end, aclk, aresetn, push.num == 2'd2, s_text_end)
    `WWML_ASSERT_NEXT(a_end_restarts, aclk, aresetn, accept && s_text_end, line_reg == 32'd1 && match_reg == '0)
    `WWML_ASSERT_NEXT(a_line_clears, aclk, aresetn, accept && marker, bytes_reg == '0)

endmodule

`default_nettype wire
